// ----- hdl/lfw_pkg.sv -----
// Shared types and constants of the lagged Fibonacci / Weyl random generator.
package lfw_pkg;

   localparam int DATA_W    = 53;
   localparam int SEED_W    = 64;
   localparam int BITS_W    = 32;
   localparam int IDX_W     = 7;
   localparam int SLOTS     = 128;
   localparam int SEED_OPS  = 6;
   localparam int OP_CNT_W  = 3;

   // Weyl decrement and the gap between 2^53 and the prime 2^53-111
   localparam logic [DATA_W-1:0] WEYL_STEP = 53'd5566755282872655;
   localparam logic [DATA_W-1:0] PRIME_GAP = 53'd111;

   // Command codes
   localparam logic CMD_NEXT = 1'b0;
   localparam logic CMD_SEED = 1'b1;

   typedef struct packed {
      logic              command;
      logic [SEED_W-1:0] seed_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] fraction;
      logic [BITS_W-1:0] bits32;
   } rsp_type;

endpackage

// ----- hdl/lagged_fibonacci_weyl_prng.sv -----
// Subtractive lagged Fibonacci generator with Weyl sequence, one shared modular subtractor.
//
// A next command (command 0) is taken when start is high and busy is low; its
// 53-bit fraction and top 32 bits appear on rsp_data with rsp_strobe high for
// one cycle, registered after the difference, Weyl and output steps. The
// receiver cannot stall, so it must take every strobed result. Busy stays high
// through those steps, so no new command is taken while a value is in work:
// every step goes through the single 53-bit modular subtractor (table
// difference, Weyl step, final combination). A reseed command (command 1)
// gives no result and keeps busy high until table entries 1 to LONG_LAG are
// written: each table entry needs six passes through the subtractor (Weyl step
// and five running differences), and entries are written one at a time into
// the table through its one write port. Table slots never written read as zero.
module lagged_fibonacci_weyl_prng #(
   parameter int LONG_LAG  = 98,
   parameter int SHORT_LAG = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lfw_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lfw_pkg::rsp_type rsp_data
);
   import lfw_pkg::*;

   localparam logic [IDX_W-1:0]    LONG_IDX  = IDX_W'(LONG_LAG);
   localparam logic [IDX_W-1:0]    SHORT_IDX = IDX_W'(SHORT_LAG);
   localparam logic [OP_CNT_W-1:0] LAST_OP   = OP_CNT_W'(SEED_OPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NX_DIFF,
      ST_NX_WEYL,
      ST_NX_OUT,
      ST_SEED
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     long_ff, long_in;
   logic [IDX_W-1:0]     short_ff, short_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   logic [OP_CNT_W-1:0]  op_ff, op_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;
   // q_ff[0] holds the Weyl value at rest; all six rotate during a reseed
   logic [DATA_W-1:0]    q_ff [SEED_OPS];
   logic [DATA_W-1:0]    q_in [SEED_OPS];
   logic [DATA_W-1:0]    x_ff, x_in;

   // lag table and its written flags
   logic [DATA_W-1:0]    mem [SLOTS];
   logic [SLOTS-1:0]     vld_ff;
   logic [DATA_W-1:0]    rd_long_ff, rd_short_ff;
   logic                 rd_vld_long_ff, rd_vld_short_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [DATA_W-1:0]    op_long, op_short;

   // shared modular subtractor
   logic [DATA_W-1:0]    op_a, op_b;
   logic                 op_mod;
   logic [DATA_W:0]      sub_full;
   logic [DATA_W-1:0]    sub_wrap;
   logic [DATA_W-1:0]    amb_res;

   function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] i);
      dec_idx = (i <= IDX_W'(1)) ? LONG_IDX : i - 1'b1;
   endfunction

   // a - b, and in modular mode on borrow add the prime (same as subtracting 111 mod 2^53)
   assign sub_full = {1'b0, op_a} - {1'b0, op_b};
   assign sub_wrap = op_a - op_b - PRIME_GAP;
   assign amb_res  = (op_mod && sub_full[DATA_W]) ? sub_wrap : sub_full[DATA_W-1:0];

   assign op_long  = rd_vld_long_ff  ? rd_long_ff  : '0;
   assign op_short = rd_vld_short_ff ? rd_short_ff : '0;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // sequencer next-state and operand selection
   always_comb begin
      state_in      = state_ff;
      long_in       = long_ff;
      short_in      = short_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      q_in          = q_ff;
      x_in          = x_ff;
      wr_en         = 1'b0;
      wr_addr       = k_ff;
      op_a          = q_ff[0];
      op_b          = WEYL_STEP;
      op_mod        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.command == CMD_SEED) begin
                  for (int i = 0; i < SEED_OPS; i++) begin
                     q_in[i] = req_data.seed_value[SEED_W-1 -: DATA_W];
                  end
                  k_in     = IDX_W'(1);
                  op_in    = '0;
                  state_in = ST_SEED;
               end else begin
                  state_in = ST_NX_DIFF;
               end
            end
         end
         ST_NX_DIFF: begin
            op_a     = op_long;
            op_b     = op_short;
            op_mod   = 1'b0;
            x_in     = amb_res;
            wr_en    = 1'b1;
            wr_addr  = long_ff;
            long_in  = dec_idx(long_ff);
            short_in = dec_idx(short_ff);
            state_in = ST_NX_WEYL;
         end
         ST_NX_WEYL: begin
            q_in[0]  = amb_res;
            state_in = ST_NX_OUT;
         end
         ST_NX_OUT: begin
            op_a            = x_ff;
            op_b            = q_ff[0];
            op_mod          = 1'b0;
            rsp_in.fraction = amb_res;
            rsp_in.bits32   = amb_res[DATA_W-1 -: BITS_W];
            rsp_strobe_in   = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_SEED: begin
            // rotate: head is updated against the last result (or the Weyl step)
            op_b = (op_ff == '0) ? WEYL_STEP : q_ff[SEED_OPS-1];
            for (int i = 0; i < SEED_OPS - 1; i++) begin
               q_in[i] = q_ff[i+1];
            end
            q_in[SEED_OPS-1] = amb_res;
            if (op_ff == LAST_OP) begin
               wr_en = 1'b1;
               op_in = '0;
               if (k_ff == LONG_IDX) begin
                  long_in  = LONG_IDX;
                  short_in = SHORT_IDX;
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               op_in = op_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         long_ff       <= LONG_IDX;
         short_ff      <= SHORT_IDX;
         k_ff          <= IDX_W'(1);
         op_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
         for (int i = 0; i < SEED_OPS; i++) begin
            q_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         long_ff       <= long_in;
         short_ff      <= short_in;
         k_ff          <= k_in;
         op_ff         <= op_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ff        <= rsp_in;
         q_ff          <= q_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   // table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= amb_res;
      end
      rd_long_ff  <= mem[long_ff];
      rd_short_ff <= mem[short_ff];
   end

   // written flags: unwritten slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= '0;
         rd_vld_long_ff  <= 1'b0;
         rd_vld_short_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_long_ff  <= vld_ff[long_ff];
         rd_vld_short_ff <= vld_ff[short_ff];
      end
   end

   // a next transfer always produces a result
   a_next_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_NEXT) |-> ##4 rsp_strobe)
      else $error("next command result missing");

   // a reseed never produces a result
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_SEED) |=> ##1 !rsp_strobe)
      else $error("result during reseed");

   // lag indices never reach slot zero
   a_idx_nonzero: assert property (@(posedge clock) disable iff (reset)
      (long_ff != '0) && (short_ff != '0))
      else $error("lag index at slot zero");

   // table writes stay inside the long lag
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != '0) && (wr_addr <= LONG_IDX))
      else $error("table write out of range");

endmodule
